// File: design/sbpd_pkg.sv
// Shared types and constants of the start-byte packet deframer.
`default_nettype none

package sbpd_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IDLE_W     = 17;
	localparam int POS_W      = 6;

	// input item kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// result event codes
	localparam logic [1:0] EV_BYTE     = 2'd0;
	localparam logic [1:0] EV_CRC_ERR  = 2'd1;
	localparam logic [1:0] EV_OVERFLOW = 2'd2;
	localparam logic [1:0] EV_PARTIAL  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT   = 2'd1;

	localparam logic [7:0]        MARKER_RESET = 8'h00;
	localparam logic [15:0]       LIMIT_RESET  = 16'd10;
	localparam logic [7:0]        CRC_POLY     = 8'hD8;
	localparam int                MIN_JUDGED   = 3;
	localparam logic [IDLE_W-1:0] IDLE_MAX     = '1;

	typedef struct packed {
		logic       start;    // load a new byte into the CRC shifter
		logic       restart;  // seed the CRC with zero (packet opens)
		logic [7:0] din;
	} crc_ctl_t;

endpackage

`default_nettype wire

// File: design/sbpd_if.sv
// Channel interfaces: input items, result items and configuration writes.
`default_nettype none

interface sbpd_in_if import sbpd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] rx_byte;

	modport source(output valid, kind, rx_byte, input ready);
	modport sink(input valid, kind, rx_byte, output ready);
endinterface

interface sbpd_out_if import sbpd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       event_res;
	logic [7:0]       data;
	logic [POS_W-1:0] position;
	logic             last;

	modport source(output valid, event_res, data, position, last, input ready);
	modport sink(input valid, event_res, data, position, last, output ready);
endinterface

interface sbpd_cfg_if import sbpd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  addr;
	logic [CFG_DATA_W-1:0] wdata;

	modport source(output valid, addr, wdata, input ready);
	modport sink(input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

// File: design/start_byte_packet_deframer_crc8_top.sv
// Start-byte packet deframer with CRC-8 check.
// A stored byte occupies the bit-serial CRC unit; no new item is taken while it is busy,
// and none while an item is judged or a result is still waiting for the output register.
// A judged packet goes out byte by byte (store read, then output register), held while the receiver stalls.
// Event results pass the judge and event states (overflow: event state only) into the output register.
// arst_n clears control state and registers; the byte store is not cleared.
`default_nettype none

module start_byte_packet_deframer_crc8_top import sbpd_pkg::*; #(
	parameter int PACKET_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	sbpd_in_if.sink     in_ch,
	sbpd_out_if.source  out_ch,
	sbpd_cfg_if.sink    cfg
);

	localparam int AW = $clog2(PACKET_DEPTH);
	localparam int FW = $clog2(PACKET_DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_JUDGE = 3'd1;
	localparam logic [2:0] ST_EVT   = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]        state_q;
	logic [7:0]        marker_q;
	logic [15:0]       limit_q;
	logic [FW-1:0]     fill_q;
	logic [IDLE_W-1:0] idle_q;
	logic [7:0]        cbl_q;
	logic [7:0]        newest_q;
	logic [7:0]        byte2_q;
	logic [FW-1:0]     emit_len_q;
	logic [AW-1:0]     idx_q;
	logic [1:0]        evt_q;

	logic             out_valid_q;
	logic [1:0]       out_evt_q;
	logic [7:0]       out_data_q;
	logic [POS_W-1:0] out_pos_q;
	logic             out_last_q;

	logic          in_fire;
	logic          is_byte;
	logic          opening;
	logic          storing;
	logic [FW-1:0] fill_inc;
	logic          ovf;
	logic          out_free;
	logic          load_evt;
	logic          load_pkt;
	logic          pkt_last;
	logic [7:0]    expected;
	logic [7:0]    rdata;
	logic [7:0]    crc_val;
	logic          crc_busy;
	crc_ctl_t      crc_ctl;

	assign in_ch.ready = (state_q == ST_IDLE) && !crc_busy;
	assign cfg.ready   = 1'b1;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign is_byte  = in_ch.kind == KIND_BYTE;
	assign opening  = is_byte && (fill_q == '0) && (in_ch.rx_byte == marker_q);
	assign storing  = is_byte && ((fill_q != '0) || (in_ch.rx_byte == marker_q));
	assign fill_inc = fill_q + 1'b1;
	assign ovf      = fill_inc == FW'(PACKET_DEPTH);
	assign expected = byte2_q + 8'd1;

	assign out_free = !out_valid_q || out_ch.ready;
	assign load_evt = (state_q == ST_EVT) && out_free;
	assign load_pkt = (state_q == ST_OUT) && out_free;
	assign pkt_last = (FW'(idx_q) + 1'b1) == emit_len_q;

	assign crc_ctl.start   = in_fire && storing;
	assign crc_ctl.restart = opening;
	assign crc_ctl.din     = in_ch.rx_byte;

	sbpd_crc_bitser u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.crc    (crc_val),
		.busy   (crc_busy)
	);

	sbpd_store #(.DEPTH(PACKET_DEPTH)) u_store (
		.clk   (clk),
		.we    (in_fire && storing),
		.waddr (fill_q[AW-1:0]),
		.wdata (in_ch.rx_byte),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.addr == REG_START_MARKER) begin
				marker_q <= cfg.wdata[7:0];
			end else if (cfg.addr == REG_IDLE_LIMIT) begin
				limit_q <= cfg.wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			idle_q     <= '0;
			cbl_q      <= '0;
			newest_q   <= '0;
			byte2_q    <= '0;
			emit_len_q <= '0;
			idx_q      <= '0;
			evt_q      <= EV_BYTE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (!is_byte) begin
							if (idle_q != IDLE_MAX) begin
								idle_q <= idle_q + 1'b1;
							end
							state_q <= ST_JUDGE;
						end else if (storing) begin
							newest_q <= in_ch.rx_byte;
							cbl_q    <= opening ? 8'h00 : crc_val;
							if (fill_q == FW'(2)) begin
								byte2_q <= in_ch.rx_byte;
							end
							if (ovf) begin
								fill_q  <= '0;
								evt_q   <= EV_OVERFLOW;
								state_q <= ST_EVT;
							end else begin
								fill_q <= fill_inc;
								// the start byte leaves the idle count alone
								if (!opening) begin
									idle_q <= '0;
								end
								state_q <= ST_JUDGE;
							end
						end
					end
				end
				ST_JUDGE: begin
					if ((fill_q == '0) || (idle_q <= {1'b0, limit_q})) begin
						state_q <= ST_IDLE;
					end else if (fill_q >= FW'(MIN_JUDGED)) begin
						if (8'(fill_q) < expected) begin
							state_q <= ST_IDLE;  // still waiting for bytes
						end else if (cbl_q == newest_q) begin
							emit_len_q <= fill_q;
							idx_q      <= '0;
							fill_q     <= '0;
							state_q    <= ST_RD;
						end else begin
							fill_q  <= '0;
							evt_q   <= EV_CRC_ERR;
							state_q <= ST_EVT;
						end
					end else begin
						fill_q  <= '0;
						evt_q   <= EV_PARTIAL;
						state_q <= ST_EVT;
					end
				end
				ST_EVT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						if (pkt_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_evt_q   <= EV_BYTE;
			out_data_q  <= '0;
			out_pos_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (load_evt) begin
				out_valid_q <= 1'b1;
				out_evt_q   <= evt_q;
				out_data_q  <= '0;
				out_pos_q   <= '0;
				out_last_q  <= 1'b1;
			end else if (load_pkt) begin
				out_valid_q <= 1'b1;
				out_evt_q   <= EV_BYTE;
				out_data_q  <= rdata;
				out_pos_q   <= POS_W'(idx_q);
				out_last_q  <= pkt_last;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.event_res = out_evt_q;
	assign out_ch.data      = out_data_q;
	assign out_ch.position  = out_pos_q;
	assign out_ch.last      = out_last_q;

endmodule

`default_nettype wire

// File: design/sbpd_crc_bitser.sv
// Bit-serial CRC-8 (poly 0xD8, MSB first): one shift per cycle, eight per byte.
`default_nettype none

module sbpd_crc_bitser import sbpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  crc_ctl_t   ctl,
	output logic [7:0] crc,
	output logic       busy
);

	logic [7:0] sh_q;
	logic [2:0] cnt_q;
	logic       busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q   <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (ctl.start) begin
			sh_q   <= (ctl.restart ? 8'h00 : sh_q) ^ ctl.din;
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (sh_q[7]) begin
				sh_q <= {sh_q[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				sh_q <= {sh_q[6:0], 1'b0};
			end
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign crc  = sh_q;
	assign busy = busy_q;

endmodule

`default_nettype wire

// File: design/sbpd_store.sv
// Packet byte store: one write port, one registered read port.
`default_nettype none

module sbpd_store #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the start-byte packet deframer with CRC-8 check.
`timescale 1ns / 100ps

module tb_top;
	import sbpd_pkg::*;

	localparam int DEPTH           = 64;
	localparam int RANDOM_ITEMS    = 75;
	localparam int SETTLE_CYCLES   = 12;
	localparam int PRESSURE_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int NUM_ROWS        = 30;

	// index space beyond the two real registers; writes there must do nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [1:0]       ev;
		logic [7:0]       data;
		logic [POS_W-1:0] pos;
		logic             last;
	} frame_result_t;

	typedef enum logic [1:0] {ROW_ITEM, ROW_CRC, ROW_BAD_CRC, ROW_REG} row_op_e;

	typedef struct packed {
		row_op_e              op;
		logic                 kind;
		logic [15:0]          val;
		logic [CFG_IDX_W-1:0] idx;
		logic                 typed;
		logic [1:0]           ev;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sbpd_in_if  in_ch();
	sbpd_out_if out_ch();
	sbpd_cfg_if cfg();

	start_byte_packet_deframer_crc8_top #(.PACKET_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Directed rows: typed results are events only; packet bytes come from the predictor.
	stim_row_t dir_rows [NUM_ROWS] = '{
		// marker at its reset value, silence before it: dropped at once
		'{ROW_REG,  KIND_BYTE, 16'h0000, REG_IDLE_LIMIT,   1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_BYTE, 16'h005A, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_TICK, 16'h00FF, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_BYTE, 16'h0000, REG_START_MARKER, 1'b1, EV_PARTIAL},
		// spare indexes, then a good four-byte packet
		'{ROW_REG,  KIND_BYTE, 16'hFFFF, REG_SPARE_A,      1'b0, EV_BYTE},
		'{ROW_REG,  KIND_BYTE, 16'h1234, REG_SPARE_B,      1'b0, EV_BYTE},
		'{ROW_REG,  KIND_BYTE, 16'h0001, REG_IDLE_LIMIT,   1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_BYTE, 16'h0000, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_BYTE, 16'h0000, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_BYTE, 16'h0003, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_CRC,  KIND_BYTE, 16'h0000, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_TICK, 16'h0000, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_TICK, 16'h00FF, REG_START_MARKER, 1'b0, EV_BYTE},
		// length byte 0xFF: expected count wraps to zero
		'{ROW_REG,  KIND_BYTE, 16'h0002, REG_IDLE_LIMIT,   1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_BYTE, 16'h0000, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_BYTE, 16'h00FF, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_BYTE, 16'h00FF, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_CRC,  KIND_BYTE, 16'h0000, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_TICK, 16'h00FF, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_TICK, 16'h0000, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_TICK, 16'h00FF, REG_START_MARKER, 1'b0, EV_BYTE},
		// complete packet with a corrupted check byte
		'{ROW_REG,  KIND_BYTE, 16'h0003, REG_IDLE_LIMIT,   1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_BYTE, 16'h0000, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_BYTE, 16'h0080, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_BYTE, 16'h0003, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_BAD_CRC, KIND_BYTE, 16'h0000, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_TICK, 16'h0000, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_TICK, 16'h00FF, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_TICK, 16'h0000, REG_START_MARKER, 1'b0, EV_BYTE},
		'{ROW_ITEM, KIND_TICK, 16'h00FF, REG_START_MARKER, 1'b1, EV_CRC_ERR}
	};

	// predictor state
	logic [7:0]        m_marker   = MARKER_RESET;
	logic [15:0]       m_limit    = LIMIT_RESET;
	logic [7:0]        m_store [DEPTH];
	int                m_fill     = 0;
	logic [IDLE_W-1:0] m_idle     = '0;
	logic [7:0]        m_crc      = '0;
	logic [7:0]        m_crc_prev = '0;
	logic [7:0]        m_newest   = '0;

	frame_result_t frame_results_q[$];
	int  err_cnt        = 0;
	int  fed_items      = 0;
	int  quiet_cycles   = 0;
	int  hold_left      = 0;
	bit  gaps_on        = 1'b0;
	bit  pressure_armed = 1'b0;
	bit  pressure_done  = 1'b0;

	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		repeat (8) v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		return v;
	endfunction

	function automatic void store_byte(input logic [7:0] b);
		if (m_fill < DEPTH)
			m_store[m_fill] = b;
		m_fill++;
		m_crc_prev = m_crc;
		m_crc = crc8_next(m_crc, b);
		m_newest = b;
	endfunction

	function automatic void expect_result(input logic [1:0] ev, input logic [7:0] d,
			input int pos, input bit lst, input bit push);
		if (push)
			frame_results_q.push_back('{ev, d, pos[POS_W-1:0], lst});
	endfunction

	// Advances the deframer state by one item; returns 1 when the item changed nothing.
	function automatic bit deframe_step(input logic k, input logic [7:0] b, input bit push);
		logic [7:0] want_len;
		if (k == KIND_BYTE) begin
			if (m_fill == 0) begin
				if (b != m_marker)
					return 1'b1;
				m_crc = '0;
				store_byte(b);
			end else begin
				store_byte(b);
				if (m_fill >= DEPTH) begin
					m_fill = 0;
					expect_result(EV_OVERFLOW, 8'h00, 0, 1'b1, push);
					return 1'b0;
				end
				m_idle = '0;
			end
		end else if (m_idle != IDLE_MAX) begin
			m_idle++;
		end
		if (m_fill == 0 || m_idle <= m_limit)
			return 1'b0;
		if (m_fill >= MIN_JUDGED) begin
			want_len = m_store[2] + 8'd1;
			if (m_fill < int'(want_len))
				return 1'b0;  // still waiting for bytes
			if (m_crc_prev == m_newest) begin
				for (int i = 0; i < m_fill; i++)
					expect_result(EV_BYTE, m_store[i], i, i == m_fill - 1, push);
			end else begin
				expect_result(EV_CRC_ERR, 8'h00, 0, 1'b1, push);
			end
		end else begin
			expect_result(EV_PARTIAL, 8'h00, 0, 1'b1, push);
		end
		m_fill = 0;
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_cnt < 50)
			$display("[%0t] MISMATCH %s", $realtime, msg);
		err_cnt++;
	endtask

	task automatic check_field(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got %0h, expected %0h", what, got, want));
	endtask

	task automatic send_item(input logic k, input logic [7:0] b, input bit predict = 1'b1);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.kind    <= k;
		in_ch.rx_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		if (!deframe_step(k, b, predict))
			fed_items++;
	endtask

	task automatic wait_settled();
		while (frame_results_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
		in_ch.valid <= 1'b0;
		wait_settled();
		cfg.valid <= 1'b1;
		cfg.addr  <= idx;
		cfg.wdata <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_START_MARKER: m_marker = v[7:0];
			REG_IDLE_LIMIT:   m_limit  = v;
			default: ;
		endcase
	endtask

	// pick < 50 good packet, < 65 bad check byte, < 75 one or two bytes,
	// < 83 length byte 0xFF, < 90 runs into overflow, else noise
	task automatic run_sequence(input int pick, input bit go_long);
		int         len;
		logic [7:0] b;
		len = (go_long || $urandom_range(0, 9) == 0) ? $urandom_range(11, DEPTH - 1)
			: $urandom_range(4, 10);
		if (pick >= 90) begin
			repeat ($urandom_range(3, 12))
				send_item(1'($urandom_range(0, 1)),
					$urandom_range(0, 3) == 0 ? m_marker : 8'($urandom_range(0, 255)));
		end else begin
			if (pick >= 65 && pick < 75)
				len = $urandom_range(1, 2);
			else if (pick >= 83)
				len = DEPTH;
			send_item(KIND_BYTE, m_marker);
			for (int i = 1; i < len; i++) begin
				if (i == 2)
					b = (pick >= 83) ? 8'($urandom_range(DEPTH, 254))
						: (pick >= 75) ? 8'hFF : 8'(len - 1);
				else if (i == len - 1 && pick < 50)
					b = m_crc;
				else if (i == len - 1 && pick < 65)
					b = m_crc ^ 8'($urandom_range(1, 255));
				else if (i == len - 1 && pick < 79)
					b = m_crc;
				else
					b = 8'($urandom_range(0, 255));
				// incomplete packet sits out a timeout before more bytes arrive
				if (pick >= 83 && i == 6)
					repeat (m_limit + 2) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
				send_item(KIND_BYTE, b);
			end
			if (pick < 83)
				repeat (m_limit + 1) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 3) == 0)
			send_item(KIND_BYTE, m_marker);
	endtask

	// result checker
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (frame_results_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result ev=%0d data=%0h pos=%0d last=%0b",
					out_ch.event_res, out_ch.data, out_ch.position, out_ch.last));
			end else begin
				want = frame_results_q.pop_front();
				check_field("event_res", 8'(out_ch.event_res), 8'(want.ev));
				check_field("data", out_ch.data, want.data);
				check_field("position", 8'(out_ch.position), 8'(want.pos));
				check_field("last", 8'(out_ch.last), 8'(want.last));
			end
		end
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (pressure_armed && !pressure_done && out_ch.valid) begin
			pressure_done = 1'b1;
			hold_left = PRESSURE_CYCLES;
			out_ch.ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			hold_left = $urandom_range(0, 10);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		stim_row_t         row;
		logic [IDLE_W-1:0] lim;
		int                phase;
		in_ch.valid   <= 1'b0;
		in_ch.kind    <= KIND_BYTE;
		in_ch.rx_byte <= 8'h00;
		cfg.valid     <= 1'b0;
		cfg.addr      <= REG_START_MARKER;
		cfg.wdata     <= 16'h0000;
		arst_n        <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gaps_on = 1'b1;

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			case (row.op)
				ROW_REG:     write_reg(row.idx, row.val);
				ROW_CRC:     send_item(KIND_BYTE, m_crc);
				ROW_BAD_CRC: send_item(KIND_BYTE, m_crc ^ 8'h5A);
				default: begin
					send_item(row.kind, row.val[7:0], !row.typed);
					if (row.typed)
						frame_results_q.push_back('{row.ev, 8'h00, '0, 1'b1});
				end
			endcase
		end

		fed_items = 0;
		phase = 0;
		while (fed_items < RANDOM_ITEMS) begin
			gaps_on = (phase % 4 != 3) && (phase != 2);
			write_reg(REG_START_MARKER, phase == 0 ? 16'h00FF : phase == 1 ? 16'h0000
				: 16'($urandom_range(0, 255)));
			if ($urandom_range(0, 4) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					16'($urandom_range(0, 65535)));
			// limit must cover the idle count carried over, or the marker is dropped
			lim = IDLE_W'($urandom_range(0, 4));
			if (lim < m_idle)
				lim = m_idle;
			if (lim > 17'h0FFFF)
				lim = 17'h0FFFF;
			write_reg(REG_IDLE_LIMIT, lim[15:0]);
			if (phase == 0) begin
				pressure_armed = 1'b1;
				run_sequence(0, 1'b1);
			end
			repeat ($urandom_range(1, 3))
				run_sequence($urandom_range(0, 99), 1'b0);
			phase++;
		end

		// last stretch: no idling on either side
		gaps_on = 1'b0;
		run_sequence(0, 1'b0);

		in_ch.valid <= 1'b0;
		while (frame_results_q.size() != 0) @(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
design/sbpd_pkg.sv
design/sbpd_if.sv
design/sbpd_crc_bitser.sv
design/sbpd_store.sv
design/start_byte_packet_deframer_crc8_top.sv
tb/tb_top.sv
